// ----- hdl/prms_pkg.sv -----
// Shared types and constants for the platform run-mode sequencer.
// Used by the channel interfaces, the top level and the checker; no dependencies.
`default_nettype none

package prms_pkg;

  // Width of the per-motor flag vectors.
  localparam int FLAG_W = 6;

  // Default number of motors on the platform.
  localparam int MOTOR_COUNT_DEFAULT = 6;

  // Event codes carried in the mode field of an input word.
  typedef enum logic [2:0] {
    EV_START_STOP = 3'd0,
    EV_EMERGENCY  = 3'd1,
    EV_RESTART    = 3'd2,
    EV_HOMED      = 3'd3,
    EV_FAULT      = 3'd4,
    EV_SET_LIMIT  = 3'd5,
    EV_SET_HOMED  = 3'd6
  } event_t;

  // Run modes of the platform.
  typedef enum logic [2:0] {
    RM_IDLE    = 3'd0,
    RM_HOMING  = 3'd1,
    RM_WAIT    = 3'd2,
    RM_RUN     = 3'd3,
    RM_STOPPED = 3'd4,
    RM_ESTOP   = 3'd5,
    RM_FAULT   = 3'd6
  } run_mode_t;

  // Requested actions.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_HOME = 2'd1,
    ACT_HALT = 2'd2
  } action_t;

  // Start/stop button level.
  localparam logic LEVEL_START = 1'b0;

endpackage

`default_nettype wire

// ----- hdl/prms_if.sv -----
// Valid/ready channel interfaces for event words and result words.
// Depends on prms_pkg for the flag width.
`default_nettype none

// Event channel: one word per button, fault or flag event.
interface prms_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       level;
  logic [2:0] motor_index;
  logic       flag_value;

  modport source (output valid, output mode, output level, output motor_index,
                  output flag_value, input ready);
  modport sink   (input valid, input mode, input level, input motor_index,
                  input flag_value, output ready);
endinterface

// Result channel: one word per accepted event.
interface prms_res_if
  import prms_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [2:0]        run_mode;
  logic [1:0]        action;
  logic [FLAG_W-1:0] limit_flags;
  logic [FLAG_W-1:0] homed_flags;
  logic              all_limits;
  logic              all_homed;

  modport source (output valid, output run_mode, output action, output limit_flags,
                  output homed_flags, output all_limits, output all_homed,
                  input ready);
  modport sink   (input valid, input run_mode, input action, input limit_flags,
                  input homed_flags, input all_limits, input all_homed,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/platform_run_mode_sequencer_top.sv -----
// Run-mode sequencer top level: mode register, per-motor flags and result register.
// Depends on prms_pkg and the channel interfaces in prms_if.sv.
`default_nettype none

// Run-mode sequencer for a multi-motor platform. Each event word (start/stop
// button, emergency, restart, homing done, fault, or a write of one motor's
// limit or homed flag) updates the run mode and the flag vectors and yields
// exactly one result word holding the new mode, the requested action and both
// flag vectors with their all-set reductions. An event is taken in every cycle
// in which the result register is empty or its word is being taken, so the
// block sustains one word per clock; the single result register is the only
// pipeline stage. Motor indexes at or above the smaller of MOTOR_COUNT and the
// flag width are ignored.
module platform_run_mode_sequencer_top
  import prms_pkg::*;
#(
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  prms_evt_if.sink    evt,
  prms_res_if.source  res
);

  localparam int EFF_COUNT = (MOTOR_COUNT < FLAG_W) ? MOTOR_COUNT : FLAG_W;
  localparam logic [FLAG_W-1:0] MOTOR_MASK = FLAG_W'((1 << EFF_COUNT) - 1);

  run_mode_t         current_mode;
  run_mode_t         current_mode_next;
  logic [FLAG_W-1:0] limit_bits;
  logic [FLAG_W-1:0] limit_bits_next;
  logic [FLAG_W-1:0] homed_bits;
  logic [FLAG_W-1:0] homed_bits_next;
  action_t           action_next;
  logic [FLAG_W-1:0] motor_sel;
  logic              res_valid;
  logic              accept;

  // The result register frees up when it is empty or its word leaves.
  assign evt.ready = !res_valid || res.ready;
  assign accept    = evt.valid && evt.ready;

  // Indexes beyond the vector shift out; the mask drops unused motors.
  assign motor_sel = (FLAG_W'(1) << evt.motor_index) & MOTOR_MASK;

  // Next mode, action and flags for the word on the input.
  always_comb begin
    current_mode_next = current_mode;
    action_next       = ACT_NONE;
    limit_bits_next   = limit_bits;
    homed_bits_next   = homed_bits;
    case (evt.mode)
      EV_START_STOP: begin
        if (evt.level == LEVEL_START) begin
          if (current_mode == RM_IDLE) begin
            limit_bits_next   = '0;
            homed_bits_next   = '0;
            current_mode_next = RM_HOMING;
            action_next       = ACT_HOME;
          end else if (current_mode == RM_WAIT || current_mode == RM_STOPPED) begin
            current_mode_next = RM_RUN;
          end
        end else if (current_mode == RM_RUN) begin
          current_mode_next = RM_STOPPED;
        end
      end
      EV_EMERGENCY: begin
        if (current_mode != RM_IDLE && current_mode != RM_ESTOP &&
            current_mode != RM_FAULT) begin
          current_mode_next = RM_ESTOP;
          action_next       = ACT_HALT;
        end
      end
      EV_RESTART: begin
        if (current_mode == RM_STOPPED || current_mode == RM_ESTOP ||
            current_mode == RM_FAULT) begin
          limit_bits_next   = '0;
          homed_bits_next   = '0;
          current_mode_next = RM_HOMING;
          action_next       = ACT_HOME;
        end
      end
      EV_HOMED: begin
        if (current_mode == RM_HOMING) begin
          current_mode_next = RM_WAIT;
        end
      end
      EV_FAULT: begin
        if (current_mode != RM_ESTOP && current_mode != RM_FAULT) begin
          current_mode_next = RM_FAULT;
          action_next       = ACT_HALT;
        end
      end
      EV_SET_LIMIT: begin
        limit_bits_next = evt.flag_value ? (limit_bits | motor_sel)
                                         : (limit_bits & ~motor_sel);
      end
      EV_SET_HOMED: begin
        homed_bits_next = evt.flag_value ? (homed_bits | motor_sel)
                                         : (homed_bits & ~motor_sel);
      end
      default: begin
      end
    endcase
  end

  // Control state: mode, flag vectors and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= RM_IDLE;
      limit_bits   <= '0;
      homed_bits   <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (accept) begin
        current_mode <= current_mode_next;
        limit_bits   <= limit_bits_next & MOTOR_MASK;
        homed_bits   <= homed_bits_next & MOTOR_MASK;
        res_valid    <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      res.run_mode    <= current_mode_next;
      res.action      <= action_next;
      res.limit_flags <= limit_bits_next & MOTOR_MASK;
      res.homed_flags <= homed_bits_next & MOTOR_MASK;
      res.all_limits  <= (limit_bits_next & MOTOR_MASK) == MOTOR_MASK;
      res.all_homed   <= (homed_bits_next & MOTOR_MASK) == MOTOR_MASK;
    end
  end

  assign res.valid = res_valid;

endmodule

`default_nettype wire

// ----- hdl/prms_checker.sv -----
// Port-level assertions for the run-mode sequencer and the bind that attaches them.
// Depends on prms_pkg and platform_run_mode_sequencer_top.
`default_nettype none

module prms_checker
  import prms_pkg::*;
(
  input wire              clk,
  input wire              rst,
  input wire              res_valid,
  input wire              res_ready,
  input wire [2:0]        run_mode,
  input wire [1:0]        action,
  input wire [FLAG_W-1:0] limit_flags,
  input wire [FLAG_W-1:0] homed_flags
);

  // A stalled result word stays offered.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(run_mode) && $stable(action) &&
                               $stable(limit_flags) && $stable(homed_flags))
    else $error("result payload changed while stalled");

  // Entering homing always starts from cleared flag vectors.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && action == ACT_HOME |->
      run_mode == RM_HOMING && limit_flags == '0 && homed_flags == '0)
    else $error("homing request without cleared flags");

  // A hard stop only comes with the emergency or fault mode.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && action == ACT_HALT |-> run_mode == RM_ESTOP || run_mode == RM_FAULT)
    else $error("hard stop outside estop or fault");

endmodule

bind platform_run_mode_sequencer_top prms_checker u_prms_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .run_mode    (res.run_mode),
  .action      (res.action),
  .limit_flags (res.limit_flags),
  .homed_flags (res.homed_flags)
);

`default_nettype wire
